/* sv/suffix_array_lcp_builder_macros.svh */
// Assertion macros shared by the suffix array and LCP builder RTL.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SAL_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SAL_ASSERT(name, prop, msg)
`define SAL_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* sv/sal_pkg.sv */
// Types, constants and sequencer states of the suffix array and LCP builder.
package sal_pkg;

   localparam int MAX_TEXT_DEF = 1024;
   localparam int LEVELS_DEF   = 11;
   localparam int ALPHABET_DEF = 27;

   localparam int RANK_W   = 10;
   localparam int LETTER_W = 5;

   localparam logic KIND_LETTER = 1'b0;
   localparam logic KIND_RANK   = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [LETTER_W-1:0] letter;
      logic                last_letter;
      logic [RANK_W-1:0]   rank;
   } sal_req_type;

   typedef struct packed {
      logic [RANK_W-1:0] suffix_start;
      logic [RANK_W-1:0] common_prefix;
      logic              out_of_range;
   } sal_rsp_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } sal_stat_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_QRD,
      ST_CLRA,
      ST_CNTA_T,
      ST_CNTA_B,
      ST_CNTA_W,
      ST_PFXA_R,
      ST_PFXA_W,
      ST_PLA_T,
      ST_PLA_B,
      ST_PLA_W,
      ST_C0_S,
      ST_C0_T,
      ST_C0_W,
      ST_LV_CHK,
      ST_SH_R,
      ST_SH_W,
      ST_CLRL,
      ST_CTL_S,
      ST_CTL_C,
      ST_CTL_B,
      ST_CTL_W,
      ST_PFXL_R,
      ST_PFXL_W,
      ST_PLL_S,
      ST_PLL_C,
      ST_PLL_B,
      ST_PLL_W,
      ST_NC_S,
      ST_NC_A,
      ST_NC_B,
      ST_NC_W,
      ST_LC_S,
      ST_LC_G,
      ST_LC_CHK,
      ST_LC_LE,
      ST_LC_D,
      ST_LC_R1,
      ST_LC_R2,
      ST_LC_R3,
      ST_LC_R4,
      ST_LC_R5
   } sal_state_type;

endpackage

/* sv/sal_modadd.sv */
// Shared cyclic adder: (a + b) mod n for a, b below n.
module sal_modadd #(
   parameter int PW = 10
) (
   input  logic [PW-1:0] a,
   input  logic [PW-1:0] b,
   input  logic [PW:0]   n,
   output logic [PW-1:0] y
);

   logic [PW:0] sum;

   always_comb begin
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= n) begin
         y = PW'(sum - n);
      end else begin
         y = PW'(sum);
      end
   end

endmodule

/* sv/sal_core.sv */
// Sequencer, memories and shared adder that build the suffix array and LCP table.
module sal_core #(
   parameter int MAX_TEXT = sal_pkg::MAX_TEXT_DEF,
   parameter int LEVELS   = sal_pkg::LEVELS_DEF,
   parameter int ALPHABET = sal_pkg::ALPHABET_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  sal_pkg::sal_req_type req,
   input  logic                 rsp_free,
   output sal_pkg::sal_stat_type stat,
   output sal_pkg::sal_rsp_type  res
);
   import sal_pkg::*;
`include "suffix_array_lcp_builder_macros.svh"

   localparam int PW = $clog2(MAX_TEXT);
   localparam int LW = $clog2(LEVELS);
   localparam int AW = $clog2(ALPHABET);
   localparam int BK = (MAX_TEXT > ALPHABET) ? MAX_TEXT : ALPHABET;
   localparam int BW = $clog2(BK);

   function automatic int flog2(input logic [PW-1:0] v);
      int r;
      r = 0;
      for (int j = 0; j < PW; j++) begin
         if (v[j]) r = j;
      end
      return r;
   endfunction

   // memories
   logic [AW-1:0] text_mem [MAX_TEXT];
   logic [PW-1:0] sa_mem   [MAX_TEXT];
   logic [PW-1:0] cls_mem  [LEVELS][MAX_TEXT];
   logic [PW:0]   bkt_mem  [BK];
   logic [PW-1:0] sh_mem   [MAX_TEXT];
   logic [PW-1:0] lcp_mem  [MAX_TEXT];

   logic [AW-1:0] text_rd_ff;
   logic [PW-1:0] sa_rd_ff, cls_rd_ff, sh_rd_ff, lcp_rd_ff;
   logic [PW:0]   bkt_rd_ff;

   logic          text_we, sa_we, cls_we, bkt_we, sh_we, lcp_we;
   logic [PW-1:0] text_wa, text_ra, sa_wa, sa_ra, cls_wa, cls_ra;
   logic [PW-1:0] sh_wa, sh_ra, lcp_wa, lcp_ra;
   logic [BW-1:0] bkt_wa, bkt_ra;
   logic [LW-1:0] cls_wl, cls_rl;
   logic [AW-1:0] text_wd;
   logic [PW-1:0] sa_wd, cls_wd, sh_wd, lcp_wd;
   logic [PW:0]   bkt_wd;

   // sequencer registers
   sal_state_type state_ff, state_in;
   logic [PW-1:0] tlen_ff, tlen_in;
   logic [PW:0]   flen_ff, flen_in;
   logic          done_ff, done_in;
   logic [PW-1:0] i_ff, i_in;
   logic [BW-1:0] c_ff, c_in, lim_ff, lim_in;
   logic [PW:0]   acc_ff, acc_in;
   logic [AW-1:0] sym_ff, sym_in, prevsym_ff, prevsym_in;
   logic [PW-1:0] p_ff, p_in, c1_ff, c1_in, prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic [PW-1:0] cla_ff, cla_in;
   logic [LW-1:0] lvl_ff, lvl_in, top_ff, top_in, le_ff, le_in;
   logic [PW:0]   step_ff, step_in;
   logic [PW-1:0] nstep_ff, nstep_in;
   logic [PW-1:0] a_ff, a_in, b_ff, b_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [PW-1:0] mid_ff, mid_in, d_ff, d_in, x1_ff, x1_in, y1_ff, y1_in;
   logic          eq_ff, eq_in;
   logic [PW-1:0] qidx_ff, qidx_in;
   logic          qoor_ff, qoor_in;

   // shared adder
   logic [PW-1:0] ma_a, ma_b, ma_y;

   sal_modadd #(.PW(PW)) u_modadd (
      .a (ma_a),
      .b (ma_b),
      .n (flen_ff),
      .y (ma_y)
   );

   logic          last_i, last_c, lv_go;
   logic [AW-1:0] sym_now, letter_code;
   logic [PW-1:0] len_eff, len_new, rank_idx, new_cla;
   logic [PW:0]   bkt_dec, mid_sum;
   int            lg;

   assign last_i   = (i_ff == tlen_ff);
   assign last_c   = (c_ff == lim_ff);
   assign lv_go    = (step_ff < flen_ff) && (int'(lvl_ff) + 1 < LEVELS);
   assign rank_idx = PW'(req.rank);
   assign bkt_dec  = bkt_rd_ff - (PW+1)'(1);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} + (PW+1)'(1);
   assign lg       = flog2(mid_ff);

   always_comb begin
      if (int'(req.letter) + 1 > ALPHABET - 1) begin
         letter_code = AW'(ALPHABET - 1);
      end else begin
         letter_code = AW'({1'b0, req.letter} + (LETTER_W+1)'(1));
      end
      len_eff = done_ff ? '0 : tlen_ff;
      if (int'(len_eff) < MAX_TEXT - 1) begin
         len_new = len_eff + PW'(1);
      end else begin
         len_new = len_eff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (req.kind == KIND_RANK) begin
                  state_in = ST_QRD;
               end else if (req.last_letter) begin
                  state_in = ST_CLRA;
               end
            end
         end
         ST_QRD:    if (rsp_free) state_in = ST_IDLE;
         ST_CLRA:   if (last_c) state_in = ST_CNTA_T;
         ST_CNTA_T: state_in = ST_CNTA_B;
         ST_CNTA_B: state_in = ST_CNTA_W;
         ST_CNTA_W: state_in = last_i ? ST_PFXA_R : ST_CNTA_T;
         ST_PFXA_R: state_in = ST_PFXA_W;
         ST_PFXA_W: state_in = last_c ? ST_PLA_T : ST_PFXA_R;
         ST_PLA_T:  state_in = ST_PLA_B;
         ST_PLA_B:  state_in = ST_PLA_W;
         ST_PLA_W:  state_in = last_i ? ST_C0_S : ST_PLA_T;
         ST_C0_S:   state_in = ST_C0_T;
         ST_C0_T:   state_in = ST_C0_W;
         ST_C0_W:   state_in = last_i ? ST_LV_CHK : ST_C0_S;
         ST_LV_CHK: state_in = lv_go ? ST_SH_R : ST_LC_S;
         ST_SH_R:   state_in = ST_SH_W;
         ST_SH_W:   state_in = last_i ? ST_CLRL : ST_SH_R;
         ST_CLRL:   if (last_c) state_in = ST_CTL_S;
         ST_CTL_S:  state_in = ST_CTL_C;
         ST_CTL_C:  state_in = ST_CTL_B;
         ST_CTL_B:  state_in = ST_CTL_W;
         ST_CTL_W:  state_in = last_i ? ST_PFXL_R : ST_CTL_S;
         ST_PFXL_R: state_in = ST_PFXL_W;
         ST_PFXL_W: state_in = last_c ? ST_PLL_S : ST_PFXL_R;
         ST_PLL_S:  state_in = ST_PLL_C;
         ST_PLL_C:  state_in = ST_PLL_B;
         ST_PLL_B:  state_in = ST_PLL_W;
         ST_PLL_W:  state_in = (i_ff == '0) ? ST_NC_S : ST_PLL_S;
         ST_NC_S:   state_in = ST_NC_A;
         ST_NC_A:   state_in = ST_NC_B;
         ST_NC_B:   state_in = ST_NC_W;
         ST_NC_W:   state_in = last_i ? ST_LV_CHK : ST_NC_S;
         ST_LC_S:   state_in = ST_LC_G;
         ST_LC_G: begin
            if (i_ff <= PW'(1)) begin
               state_in = last_i ? ST_IDLE : ST_LC_S;
            end else begin
               state_in = ST_LC_CHK;
            end
         end
         ST_LC_CHK: begin
            if (lo_ff < hi_ff) begin
               state_in = ST_LC_LE;
            end else begin
               state_in = last_i ? ST_IDLE : ST_LC_S;
            end
         end
         ST_LC_LE:  state_in = ST_LC_D;
         ST_LC_D:   state_in = ST_LC_R1;
         ST_LC_R1:  state_in = ST_LC_R2;
         ST_LC_R2:  state_in = ST_LC_R3;
         ST_LC_R3:  state_in = ST_LC_R4;
         ST_LC_R4:  state_in = ST_LC_R5;
         ST_LC_R5:  state_in = ST_LC_CHK;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      tlen_in = tlen_ff;     flen_in = flen_ff;     done_in = done_ff;
      i_in = i_ff;           c_in = c_ff;           lim_in = lim_ff;
      acc_in = acc_ff;       sym_in = sym_ff;       prevsym_in = prevsym_ff;
      p_in = p_ff;           c1_in = c1_ff;         prev1_in = prev1_ff;
      prev2_in = prev2_ff;   cla_in = cla_ff;       lvl_in = lvl_ff;
      top_in = top_ff;       le_in = le_ff;         step_in = step_ff;
      nstep_in = nstep_ff;   a_in = a_ff;           b_in = b_ff;
      lo_in = lo_ff;         hi_in = hi_ff;         mid_in = mid_ff;
      d_in = d_ff;           x1_in = x1_ff;         y1_in = y1_ff;
      eq_in = eq_ff;         qidx_in = qidx_ff;     qoor_in = qoor_ff;
      text_we = 1'b0; sa_we = 1'b0; cls_we = 1'b0;
      bkt_we = 1'b0;  sh_we = 1'b0; lcp_we = 1'b0;
      text_wa = len_eff; text_wd = letter_code; text_ra = i_ff;
      sa_wa = bkt_dec[PW-1:0]; sa_wd = i_ff; sa_ra = i_ff;
      cls_wl = lvl_ff; cls_wa = p_ff; cls_wd = '0; cls_rl = lvl_ff; cls_ra = '0;
      bkt_wa = c_ff; bkt_wd = '0; bkt_ra = c_ff;
      sh_wa = i_ff; sh_wd = ma_y; sh_ra = i_ff;
      lcp_wa = i_ff; lcp_wd = '0; lcp_ra = qidx_ff;
      ma_a = sa_rd_ff; ma_b = nstep_ff;
      sym_now = (i_ff == tlen_ff) ? '0 : text_rd_ff;
      new_cla = cla_ff;
      case (state_ff)
         ST_IDLE: begin
            sa_ra = rank_idx;
            lcp_ra = rank_idx;
            if (go) begin
               if (req.kind == KIND_RANK) begin
                  qidx_in = rank_idx;
                  qoor_in = !done_ff || (req.rank == '0) ||
                            (int'(req.rank) > int'(tlen_ff));
               end else begin
                  done_in = 1'b0;
                  text_we = (int'(len_eff) < MAX_TEXT - 1);
                  tlen_in = len_new;
                  if (req.last_letter) begin
                     flen_in = {1'b0, len_new} + (PW+1)'(1);
                     c_in = '0;
                     lim_in = BW'(ALPHABET - 1);
                  end
               end
            end
         end
         ST_QRD: begin
            sa_ra = qidx_ff;
         end
         ST_CLRA, ST_CLRL: begin
            bkt_we = 1'b1;
            if (last_c) begin
               i_in = '0;
            end else begin
               c_in = c_ff + BW'(1);
            end
         end
         ST_CNTA_B, ST_PLA_B: begin
            sym_in = sym_now;
            bkt_ra = BW'(sym_now);
         end
         ST_CNTA_W: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(sym_ff);
            bkt_wd = bkt_rd_ff + (PW+1)'(1);
            if (last_i) begin
               c_in = '0;
               acc_in = '0;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_PFXA_W, ST_PFXL_W: begin
            bkt_we = 1'b1;
            bkt_wd = bkt_rd_ff + acc_ff;
            acc_in = bkt_rd_ff + acc_ff;
            if (last_c) begin
               i_in = (state_ff == ST_PFXA_W) ? '0 : tlen_ff;
            end else begin
               c_in = c_ff + BW'(1);
            end
         end
         ST_PLA_W: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(sym_ff);
            bkt_wd = bkt_dec;
            sa_we = 1'b1;
            sa_wd = i_ff;
            if (last_i) begin
               i_in = '0;
               cla_in = '0;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_C0_T: begin
            p_in = sa_rd_ff;
            text_ra = sa_rd_ff;
         end
         ST_C0_W: begin
            sym_in = (p_ff < tlen_ff) ? text_rd_ff : '0;
            if (i_ff != '0 && sym_in != prevsym_ff) begin
               new_cla = cla_ff + PW'(1);
            end else if (i_ff == '0) begin
               new_cla = '0;
            end
            cls_we = 1'b1;
            cls_wl = '0;
            cls_wd = new_cla;
            cla_in = new_cla;
            prevsym_in = sym_in;
            if (last_i) begin
               lvl_in = '0;
               step_in = (PW+1)'(1);
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_LV_CHK: begin
            i_in = '0;
            if (lv_go) begin
               nstep_in = PW'(flen_ff - step_ff);
            end else begin
               top_in = lvl_ff;
            end
         end
         ST_SH_W: begin
            sh_we = 1'b1;
            if (last_i) begin
               c_in = '0;
               lim_in = BW'(cla_ff);
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_CTL_C, ST_PLL_C: begin
            p_in = sh_rd_ff;
            cls_ra = sh_rd_ff;
         end
         ST_CTL_B, ST_PLL_B: begin
            c1_in = cls_rd_ff;
            bkt_ra = BW'(cls_rd_ff);
         end
         ST_CTL_W: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(c1_ff);
            bkt_wd = bkt_rd_ff + (PW+1)'(1);
            if (last_i) begin
               c_in = '0;
               acc_in = '0;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_PLL_W: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(c1_ff);
            bkt_wd = bkt_dec;
            sa_we = 1'b1;
            sa_wd = p_ff;
            if (i_ff != '0) i_in = i_ff - PW'(1);
         end
         ST_NC_A: begin
            p_in = sa_rd_ff;
            cls_ra = sa_rd_ff;
         end
         ST_NC_B: begin
            c1_in = cls_rd_ff;
            ma_a = p_ff;
            ma_b = PW'(step_ff);
            cls_ra = ma_y;
         end
         ST_NC_W: begin
            if (i_ff == '0) begin
               new_cla = '0;
            end else if (c1_ff != prev1_ff || cls_rd_ff != prev2_ff) begin
               new_cla = cla_ff + PW'(1);
            end
            cls_we = 1'b1;
            cls_wl = lvl_ff + LW'(1);
            cls_wd = new_cla;
            cla_in = new_cla;
            prev1_in = c1_ff;
            prev2_in = cls_rd_ff;
            if (last_i) begin
               lvl_in = lvl_ff + LW'(1);
               step_in = step_ff << 1;
            end else begin
               i_in = i_ff + PW'(1);
            end
         end
         ST_LC_G: begin
            b_in = sa_rd_ff;
            if (i_ff <= PW'(1)) begin
               lcp_we = 1'b1;
               a_in = sa_rd_ff;
               if (last_i) begin
                  done_in = 1'b1;
               end else begin
                  i_in = i_ff + PW'(1);
               end
            end else begin
               lo_in = '0;
               hi_in = tlen_ff;
            end
         end
         ST_LC_CHK: begin
            if (lo_ff < hi_ff) begin
               mid_in = mid_sum[PW:1];
            end else begin
               lcp_we = 1'b1;
               lcp_wd = lo_ff;
               a_in = b_ff;
               if (last_i) begin
                  done_in = 1'b1;
               end else begin
                  i_in = i_ff + PW'(1);
               end
            end
         end
         ST_LC_LE: begin
            le_in = (lg > int'(top_ff)) ? top_ff : LW'(lg);
         end
         ST_LC_D: begin
            d_in = mid_ff - (PW'(1) << le_ff);
         end
         ST_LC_R1: begin
            cls_rl = le_ff;
            cls_ra = a_ff;
         end
         ST_LC_R2: begin
            x1_in = cls_rd_ff;
            cls_rl = le_ff;
            cls_ra = b_ff;
         end
         ST_LC_R3: begin
            eq_in = (x1_ff == cls_rd_ff);
            ma_a = a_ff;
            ma_b = d_ff;
            cls_rl = le_ff;
            cls_ra = ma_y;
         end
         ST_LC_R4: begin
            y1_in = cls_rd_ff;
            ma_a = b_ff;
            ma_b = d_ff;
            cls_rl = le_ff;
            cls_ra = ma_y;
         end
         ST_LC_R5: begin
            if (eq_ff && y1_ff == cls_rd_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - PW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (text_we) text_mem[text_wa] <= text_wd;
      text_rd_ff <= text_mem[text_ra];
   end

   always_ff @(posedge clock) begin
      if (sa_we) sa_mem[sa_wa] <= sa_wd;
      sa_rd_ff <= sa_mem[sa_ra];
   end

   always_ff @(posedge clock) begin
      if (cls_we) cls_mem[cls_wl][cls_wa] <= cls_wd;
      cls_rd_ff <= cls_mem[cls_rl][cls_ra];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
      bkt_rd_ff <= bkt_mem[bkt_ra];
   end

   always_ff @(posedge clock) begin
      if (sh_we) sh_mem[sh_wa] <= sh_wd;
      sh_rd_ff <= sh_mem[sh_ra];
   end

   always_ff @(posedge clock) begin
      if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
      lcp_rd_ff <= lcp_mem[lcp_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tlen_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tlen_ff  <= tlen_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      flen_ff <= flen_in;       i_ff <= i_in;             c_ff <= c_in;
      lim_ff <= lim_in;         acc_ff <= acc_in;         sym_ff <= sym_in;
      prevsym_ff <= prevsym_in; p_ff <= p_in;             c1_ff <= c1_in;
      prev1_ff <= prev1_in;     prev2_ff <= prev2_in;     cla_ff <= cla_in;
      lvl_ff <= lvl_in;         top_ff <= top_in;         le_ff <= le_in;
      step_ff <= step_in;       nstep_ff <= nstep_in;     a_ff <= a_in;
      b_ff <= b_in;             lo_ff <= lo_in;           hi_ff <= hi_in;
      mid_ff <= mid_in;         d_ff <= d_in;             x1_ff <= x1_in;
      y1_ff <= y1_in;           eq_ff <= eq_in;           qidx_ff <= qidx_in;
      qoor_ff <= qoor_in;
   end

   // outputs
   always_comb begin
      stat.idle      = (state_ff == ST_IDLE);
      stat.res_valid = (state_ff == ST_QRD) && rsp_free;
      if (qoor_ff) begin
         res.suffix_start  = '0;
         res.common_prefix = '0;
      end else begin
         res.suffix_start  = RANK_W'({1'b0, sa_rd_ff} + (PW+1)'(1));
         res.common_prefix = RANK_W'(lcp_rd_ff);
      end
      res.out_of_range = qoor_ff;
   end

   `SAL_ASSERT(a_search_bounds, (state_ff == ST_LC_CHK) |-> (lo_ff <= hi_ff), "lcp bounds crossed")
   `SAL_ASSERT(a_mid_range, (state_ff == ST_LC_LE) |-> (mid_ff > lo_ff && mid_ff <= hi_ff), "bad probe")
   `SAL_ASSERT(a_level_range, (state_ff == ST_NC_W) |-> (int'(lvl_ff) + 1 < LEVELS), "level overflow")
   `SAL_ASSERT(a_done_source, $rose(done_ff) |-> ($past(state_ff) == ST_LC_CHK || $past(state_ff) == ST_LC_G), "bad done")
   `SAL_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !done_ff), "not idle after reset")

endmodule

/* sv/suffix_array_lcp_builder.sv */
// Letters are taken while idle. A rank query holds off requests until its result is
// registered, which waits until the response register is free. The build after the
// final letter runs on one shared adder and memories with one read and one write
// port each; no request is taken meanwhile.
// Reset is synchronous: clears text length, build status and result valid;
// memories are not cleared.
module suffix_array_lcp_builder #(
   parameter int MAX_TEXT = sal_pkg::MAX_TEXT_DEF,
   parameter int LEVELS   = sal_pkg::LEVELS_DEF,
   parameter int ALPHABET = sal_pkg::ALPHABET_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sal_pkg::sal_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sal_pkg::sal_rsp_type rsp_data
);
   import sal_pkg::*;

   sal_stat_type stat;
   sal_rsp_type  res;
   sal_rsp_type  rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = stat.idle;

   sal_core #(
      .MAX_TEXT (MAX_TEXT),
      .LEVELS   (LEVELS),
      .ALPHABET (ALPHABET)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .go       (req_valid && req_ready),
      .req      (req_data),
      .rsp_free (rsp_free),
      .stat     (stat),
      .res      (res)
   );

   // hold result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (stat.res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* test/suffix_rank_scoreboard.sv */
// Scoreboard that predicts suffix order and common prefix answers for rank reads.
`timescale 1ns / 1ps

class suffix_rank_scoreboard;
   typedef logic [sal_pkg::RANK_W-1:0] rank_bits_type;

   sal_pkg::sal_rsp_type expected_answers[$];
   int                   mismatches;
   int unsigned          letters[1024];
   int unsigned          text_len;
   int unsigned          full_len;
   int unsigned          top_level;
   bit                   built;
   int unsigned          order[1024];
   int unsigned          classes[11][1024];
   int unsigned          counts[1051];
   int unsigned          shifted[1024];
   int unsigned          lcp[1024];

   function int unsigned sym(int unsigned p);
      return (p < text_len) ? letters[p] : 0;
   endfunction

   function bit prefix_match(int unsigned a, int unsigned b, int unsigned m);
      int unsigned le, k, pa, pb;
      if (m == 0) return 1'b1;
      le = 0;
      while ((m >> (le + 1)) != 0) le++;
      if (le > top_level) le = top_level;
      k = 1 << le;
      pa = (a + m - k) % full_len;
      pb = (b + m - k) % full_len;
      return classes[le][a] == classes[le][b] && classes[le][pa] == classes[le][pb];
   endfunction

   function int unsigned common_len(int unsigned a, int unsigned b);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = full_len - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (prefix_match(a, b, mid)) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function void sort_text();
      int unsigned cla, l, step, p, q;
      full_len = text_len + 1;
      for (int c = 0; c < 27; c++) counts[c] = 0;
      for (int i = 0; i < full_len; i++) counts[sym(i)]++;
      for (int c = 1; c < 27; c++) counts[c] += counts[c-1];
      for (int i = 0; i < full_len; i++) begin
         counts[sym(i)]--;
         order[counts[sym(i)]] = i;
      end
      cla = 0;
      classes[0][order[0]] = 0;
      for (int i = 1; i < full_len; i++) begin
         if (sym(order[i]) != sym(order[i-1])) cla++;
         classes[0][order[i]] = cla;
      end
      l = 0;
      while ((1 << l) < full_len && l + 1 < 11) begin
         step = 1 << l;
         for (int i = 0; i < full_len; i++) shifted[i] = (order[i] + full_len - step) % full_len;
         for (int c = 0; c <= cla; c++) counts[c] = 0;
         for (int i = 0; i < full_len; i++) counts[classes[l][shifted[i]]]++;
         for (int c = 1; c <= cla; c++) counts[c] += counts[c-1];
         for (int i = full_len - 1; i >= 0; i--) begin
            counts[classes[l][shifted[i]]]--;
            order[counts[classes[l][shifted[i]]]] = shifted[i];
         end
         cla = 0;
         classes[l+1][order[0]] = 0;
         for (int i = 1; i < full_len; i++) begin
            p = order[i];
            q = order[i-1];
            if (classes[l][p] != classes[l][q] ||
                classes[l][(p + step) % full_len] != classes[l][(q + step) % full_len]) cla++;
            classes[l+1][p] = cla;
         end
         l++;
      end
      top_level = l;
      lcp[0] = 0;
      for (int i = 1; i < full_len; i++)
         lcp[i] = (i == 1) ? 0 : common_len(order[i-1], order[i]);
      built = 1'b1;
   endfunction

   function void note_request(sal_pkg::sal_req_type r);
      int unsigned code;
      sal_pkg::sal_rsp_type a;
      if (r.kind == sal_pkg::KIND_LETTER) begin
         code = r.letter + 1;
         if (code > 26) code = 26;
         if (built) begin
            built = 1'b0;
            text_len = 0;
         end
         if (text_len < 1023) begin
            letters[text_len] = code;
            text_len++;
         end
         if (r.last_letter && text_len > 0) sort_text();
      end else begin
         a = '0;
         if (!built || r.rank == 0 || r.rank > text_len) a.out_of_range = 1'b1;
         else begin
            a.suffix_start = rank_bits_type'(order[r.rank] + 1);
            a.common_prefix = rank_bits_type'(lcp[r.rank]);
         end
         expected_answers.push_back(a);
      end
   endfunction

   function void check_response(sal_pkg::sal_rsp_type r);
      sal_pkg::sal_rsp_type a;
      if (expected_answers.size() == 0) begin
         if (mismatches < 10) $display("unexpected response %p", r);
         mismatches++;
         return;
      end
      a = expected_answers.pop_front();
      if (r.suffix_start != a.suffix_start || r.common_prefix != a.common_prefix ||
          r.out_of_range != a.out_of_range) begin
         if (mismatches < 10)
            $display("response mismatch: expected start %0d prefix %0d oor %0d, got %0d %0d %0d",
                     a.suffix_start, a.common_prefix, a.out_of_range,
                     r.suffix_start, r.common_prefix, r.out_of_range);
         mismatches++;
      end
   endfunction
endclass

/* test/suffix_array_lcp_builder_test.sv */
// Top-level testbench of the suffix array and LCP builder.
`timescale 1ns / 1ps

module suffix_array_lcp_builder_test;
   import sal_pkg::*;

   localparam int CYCLE_LIMIT = 8000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sal_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sal_rsp_type rsp_data;

   int          req_idle_pct = 17;
   int          rsp_idle_pct = 59;
   int          sent_count;
   int          cycle_count;
   suffix_rank_scoreboard sb;

   suffix_array_lcp_builder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic sal_req_type letter_req(int unsigned code, bit last);
      sal_req_type r;
      r.kind = KIND_LETTER;
      r.letter = LETTER_W'(code);
      r.last_letter = last;
      r.rank = RANK_W'($urandom_range(1023));
      return r;
   endfunction

   function automatic sal_req_type rank_req(int unsigned rank);
      sal_req_type r;
      r.kind = KIND_RANK;
      r.letter = LETTER_W'($urandom_range(31));
      r.last_letter = 1'($urandom_range(1));
      r.rank = RANK_W'(rank);
      return r;
   endfunction

   task automatic send_request(input sal_req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      sent_count++;
   endtask

   function automatic int unsigned pick_letter();
      return ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(2);
   endfunction

   task automatic send_text(input int len);
      for (int i = 0; i < len; i++) send_request(letter_req(pick_letter(), i == len - 1));
   endtask

   task automatic send_queries(input int n, input int len);
      int unsigned rk;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: rk = 0;
            1: rk = len + 1;
            2: rk = $urandom_range(1023);
            default: rk = $urandom_range(len, 1);
         endcase
         send_request(rank_req(rk));
      end
   endtask

   task automatic run_random(input int count);
      int stop_at, len;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
         if ($urandom_range(99) < 85) begin
            send_text(len);
            send_queries($urandom_range(len + 3, 1), len);
         end else begin
            for (int i = 0; i < $urandom_range(3, 1); i++)
               send_request(letter_req(pick_letter(), 1'b0));
            send_queries($urandom_range(3, 1), len);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_request(rank_req(1));
      send_request(letter_req(0, 1'b1));
      send_request(rank_req(0));
      send_request(rank_req(1));
      send_request(rank_req(2));
      send_request(letter_req(25, 1'b0));
      send_request(letter_req(31, 1'b0));
      send_request(letter_req(0, 1'b0));
      send_request(letter_req(0, 1'b1));
      send_request(rank_req(1023));
      for (int i = 1; i <= 4; i++) send_request(rank_req(i));
      send_request(letter_req(1, 1'b0));
      send_request(letter_req(0, 1'b0));
      send_request(letter_req(13, 1'b0));
      send_request(letter_req(0, 1'b0));
      send_request(letter_req(13, 1'b0));
      send_request(letter_req(0, 1'b1));
      for (int i = 1; i <= 6; i++) send_request(rank_req(i));

      run_random(300);
      req_idle_pct = 59;
      rsp_idle_pct = 17;
      run_random(300);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_text(1030);
      send_request(rank_req(1023));
      for (int i = 0; i < 60; i++) send_request(rank_req($urandom_range(1023)));
      run_random(300);

      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
